[src/sgmd_pkg.sv]
package sgmd_pkg;

  // pixel, gradient, frame size and configuration widths
  localparam int GRAY_W     = 10;
  localparam int GRAD_W     = 14;
  localparam int IMG_W_W    = 12;
  localparam int IMG_H_W    = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;

  // configuration register indexes
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_IMAGE_WIDTH  = 1'b0;
  localparam cfg_idx_t CFG_IMAGE_HEIGHT = 1'b1;

  localparam logic [IMG_W_W-1:0] WIDTH_RST  = 12'd640;
  localparam logic [IMG_H_W-1:0] HEIGHT_RST = 13'd480;

  // back end arithmetic
  localparam int SQ_W       = 26;
  localparam int SQRT_STEPS = 13;
  localparam int CNT_W      = 4;
  localparam logic [CNT_W-1:0] CNT_MAG  = 4'd13;
  localparam logic [CNT_W-1:0] CNT_LAST = 4'd15;
  localparam logic [SQ_W-1:0] SQRT_BIT0 = 26'd1 << 24;
  localparam logic [14:0] RECIP3   = 15'd21846;
  localparam logic [7:0]  MAG_MAX  = 8'd255;
  localparam logic [7:0]  DIR_FLAT = 8'd180;
  localparam logic [7:0]  DIR_HALF = 8'd90;
  localparam logic [7:0]  DIR_TOP  = 8'd179;
  localparam int QUEUE_DEPTH = 4;

  // trig tables, whole degrees 0..90, unsigned Q50
  localparam int TRIG_W  = 51;
  localparam int TRIG_AW = 7;
  localparam int PROD_W  = GRAD_W + TRIG_W + 1;
  localparam real PI_DEG    = 3.14159265358979323846 / 180.0;
  localparam real SCALE_Q50 = 1125899906842624.0;
  localparam logic [TRIG_W-1:0] Q_ONE = 51'd1 << 50;

  typedef logic [TRIG_W-1:0] trig_tab_t [0:90];

  function automatic trig_tab_t build_sin_tab();
    trig_tab_t t;
    for (int k = 0; k <= 90; k++) begin
      t[k] = TRIG_W'(longint'($sin(real'(k) * PI_DEG) * SCALE_Q50));
    end
    t[0]  = '0;
    t[90] = Q_ONE;
    return t;
  endfunction

  function automatic trig_tab_t build_cos_tab();
    trig_tab_t t;
    for (int k = 0; k <= 90; k++) begin
      t[k] = TRIG_W'(longint'($cos(real'(k) * PI_DEG) * SCALE_Q50));
    end
    // 45 degrees uses the sine value so the diagonal compare is exact
    t[45] = TRIG_W'(longint'($sin(45.0 * PI_DEG) * SCALE_Q50));
    t[0]  = Q_ONE;
    t[90] = '0;
    return t;
  endfunction

  localparam trig_tab_t SIN_TAB = build_sin_tab();
  localparam trig_tab_t COS_TAB = build_cos_tab();

  // one gradient job between front and back
  typedef struct packed {
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic                     last;
  } sgmd_job_t;

  typedef struct packed {
    logic      valid;
    sgmd_job_t job;
  } job_req_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SQR,
    BK_ADD,
    BK_RUN,
    BK_DONE
  } back_state_t;

endpackage

[src/sgmd_if.sv]
interface sgmd_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  modport source (output valid, op, red, green, blue, input ready);
  modport sink (input valid, op, red, green, blue, output ready);
endinterface

interface sgmd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] magnitude;
  logic [7:0] direction;
  logic       last_of_frame;
  modport source (output valid, magnitude, direction, last_of_frame, input ready);
  modport sink (input valid, magnitude, direction, last_of_frame, output ready);
endinterface

[src/sobel_gradient_magnitude_direction.sv]
// channel  dir  handshake            payload
// in_req   in   valid/ready          op, red, green, blue
// out_res  out  valid/ready          magnitude, direction, last_of_frame
// cfg      in   cfg_we, no ready     cfg_index, cfg_data
//
// the front takes a new request only once the last has left (line store read,
// then write back), and waits on a full job queue when it completes a result
// the back makes one result at a time: the square root and the 8-step angle
// search share its run state, plus load, squaring, summing and handoff; front
// and back are decoupled by a 4-entry job queue; pads and edge pixels that
// complete no result never wait on the queue; reset is synchronous; line stores are not cleared and need no sweep
module sobel_gradient_magnitude_direction import sgmd_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  sgmd_in_if.sink               in_req,
  sgmd_out_if.source            out_res,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [IMG_W_W-1:0] width_r;
  logic [IMG_H_W-1:0] height_r;
  job_req_t push, head;
  logic     push_ready, pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  width_r  <= cfg_data[IMG_W_W-1:0];
        CFG_IMAGE_HEIGHT: height_r <= cfg_data[IMG_H_W-1:0];
        default: ;
      endcase
    end
  end

  sgmd_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .image_width  (width_r),
    .image_height (height_r),
    .in_req       (in_req),
    .push         (push),
    .push_ready   (push_ready)
  );

  sgmd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (push_ready),
    .head       (head),
    .pop        (pop)
  );

  sgmd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (head),
    .pop     (pop),
    .out_res (out_res)
  );

endmodule

[src/sgmd_front.sv]
module sgmd_front import sgmd_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [IMG_W_W-1:0] image_width,
  input  logic [IMG_H_W-1:0] image_height,
  sgmd_in_if.sink            in_req,
  output job_req_t           push,
  input  logic               push_ready
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 2);
  localparam int YW = RW + 1;
  localparam int COL_W = 3 * GRAY_W;

  logic [GRAY_W-1:0] line_up [MAX_WIDTH];
  logic [GRAY_W-1:0] line_mid [MAX_WIDTH];

  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic          busy_r;
  logic [GRAY_W-1:0] gray_r, up_rd_r, mid_rd_r;
  logic [CW-1:0] addr_r;
  logic has_r, top_r, bot_r, left_r, right_r, last_r;
  logic [COL_W-1:0] win0_r, win1_r, win2_r;

  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic          off_grid, accept, advance;
  logic [CW-1:0] c, cx;
  logic [RW-1:0] r;
  logic signed [YW-1:0] cy;
  logic [GRAY_W-1:0] gray;
  logic has, top, bot, left_e, right_e, last;
  logic [CW-1:0] col_nxt;
  logic [RW-1:0] row_nxt;
  logic [COL_W-1:0] col_new;
  logic [GRAY_W-1:0] g [3][3];
  logic signed [GRAD_W-1:0] gx, gy;

  // effective frame size
  always_comb begin
    if (image_width == '0) w_eff = WW'(1);
    else if (int'(image_width) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(image_width);
    if (image_height == '0) h_eff = HW'(1);
    else if (int'(image_height) > MAX_HEIGHT) h_eff = HW'(MAX_HEIGHT);
    else h_eff = HW'(image_height);
  end

  assign accept  = in_req.valid && !busy_r;
  assign advance = busy_r && (!has_r || push_ready);
  assign in_req.ready = !busy_r;

  // position of this request and the pixel it completes
  always_comb begin
    off_grid = (int'(col_r) >= int'(w_eff)) || (int'(row_r) > int'(h_eff) + 1) ||
               ((int'(row_r) == int'(h_eff) + 1) && (col_r != '0));
    c = off_grid ? '0 : col_r;
    r = off_grid ? '0 : row_r;
    if (!in_req.op && (int'(r) < int'(h_eff)))
      gray = GRAY_W'(in_req.red) + GRAY_W'(in_req.green) + GRAY_W'(in_req.blue);
    else
      gray = '0;
    cy = $signed({1'b0, r}) - ((c != '0) ? YW'(1) : YW'(2));
    cx = (c != '0) ? c - CW'(1) : CW'(w_eff - WW'(1));
    has     = !cy[YW-1] && (int'(cy) < int'(h_eff));
    top     = (cy == '0);
    bot     = (int'(cy) == int'(h_eff) - 1);
    left_e  = (cx == '0);
    right_e = (int'(cx) == int'(w_eff) - 1);
    last    = has && bot && right_e;
    if (int'(c) + 1 >= int'(w_eff)) begin
      col_nxt = '0;
      row_nxt = r + RW'(1);
    end else begin
      col_nxt = c + CW'(1);
      row_nxt = r;
    end
    if (last) begin
      col_nxt = '0;
      row_nxt = '0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      busy_r <= 1'b0;
      win0_r <= '0;
      win1_r <= '0;
      win2_r <= '0;
    end else begin
      if (accept) begin
        col_r  <= col_nxt;
        row_r  <= row_nxt;
        busy_r <= 1'b1;
      end else if (advance) begin
        busy_r <= 1'b0;
      end
      if (advance) begin
        win0_r <= win1_r;
        win1_r <= win2_r;
        win2_r <= col_new;
      end
    end
  end

  // stage registers and line stores
  always_ff @(posedge clk) begin
    if (accept) begin
      gray_r   <= gray;
      addr_r   <= c;
      has_r    <= has;
      top_r    <= top;
      bot_r    <= bot;
      left_r   <= left_e;
      right_r  <= right_e;
      last_r   <= last;
      up_rd_r  <= line_up[c];
      mid_rd_r <= line_mid[c];
    end
    if (advance) begin
      line_up[addr_r]  <= mid_rd_r;
      line_mid[addr_r] <= gray_r;
    end
  end

  assign col_new = {gray_r, mid_rd_r, up_rd_r};

  // 3x3 window with frame-edge masking
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      g[i][0] = win1_r[GRAY_W*i +: GRAY_W];
      g[i][1] = win2_r[GRAY_W*i +: GRAY_W];
      g[i][2] = col_new[GRAY_W*i +: GRAY_W];
    end
    for (int i = 0; i < 3; i++) begin
      if (left_r) g[i][0] = '0;
      if (right_r) g[i][2] = '0;
      if (top_r) g[0][i] = '0;
      if (bot_r) g[2][i] = '0;
    end
    gx = $signed(GRAD_W'(g[0][2]) + (GRAD_W'(g[1][2]) << 1) + GRAD_W'(g[2][2]))
       - $signed(GRAD_W'(g[0][0]) + (GRAD_W'(g[1][0]) << 1) + GRAD_W'(g[2][0]));
    gy = $signed(GRAD_W'(g[2][0]) + (GRAD_W'(g[2][1]) << 1) + GRAD_W'(g[2][2]))
       - $signed(GRAD_W'(g[0][0]) + (GRAD_W'(g[0][1]) << 1) + GRAD_W'(g[0][2]));
  end

  assign push.valid    = busy_r && has_r;
  assign push.job.gx   = gx;
  assign push.job.gy   = gy;
  assign push.job.last = last_r;

endmodule

[src/sgmd_queue.sv]
module sgmd_queue import sgmd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  job_req_t push,
  output logic     push_ready,
  output job_req_t head,
  input  logic     pop
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  sgmd_job_t       entry_r [QUEUE_DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [AW:0]     count_r;
  logic            do_push, do_pop;

  assign push_ready = (int'(count_r) < QUEUE_DEPTH);
  assign do_push    = push.valid && push_ready;
  assign do_pop     = pop && (count_r != '0);
  assign head.valid = (count_r != '0);
  assign head.job   = entry_r[rd_ptr_r];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + AW'(1);
      if (do_pop) rd_ptr_r <= rd_ptr_r + AW'(1);
      if (do_push && !do_pop) count_r <= count_r + (AW+1)'(1);
      else if (do_pop && !do_push) count_r <= count_r - (AW+1)'(1);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) entry_r[wr_ptr_r] <= push.job;
  end

endmodule

[src/sgmd_back.sv]
module sgmd_back import sgmd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  job_req_t   head,
  output logic       pop,
  sgmd_out_if.source out_res
);

  back_state_t state_r, state_nxt;

  logic signed [GRAD_W-1:0] x_r, y_r;
  logic yzero_r, xneg_r, last_r;
  logic [2*GRAD_W-1:0] sqa_r, sqb_r;
  logic [SQ_W-1:0] v_r, res_r, bit_r;
  logic [CNT_W-1:0] cnt_r;
  logic [7:0] lo_r, hi_r, mid_r, mag_r;
  logic signed [PROD_W-1:0] py_r, px_r;

  logic [7:0] mid;
  logic [TRIG_AW-1:0] kk;
  logic signed [TRIG_W:0] cval, sval;
  logic signed [PROD_W-1:0] py_nxt, px_nxt, diff;
  logic [SQ_W-1:0] trial;
  logic [27:0] q3;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: if (head.valid) state_nxt = BK_SQR;
      BK_SQR:  state_nxt = BK_ADD;
      BK_ADD:  state_nxt = BK_RUN;
      BK_RUN:  if (cnt_r == CNT_LAST) state_nxt = BK_DONE;
      BK_DONE: if (out_res.ready) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop           = (state_r == BK_IDLE) && head.valid;
    out_res.valid = (state_r == BK_DONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= BK_IDLE;
    else state_r <= state_nxt;
  end

  // angle probe for the current search midpoint
  always_comb begin
    mid  = 8'((9'(lo_r) + 9'(hi_r) + 9'd1) >> 1);
    kk   = (mid <= DIR_HALF) ? TRIG_AW'(mid) : TRIG_AW'(DIR_FLAT - mid);
    sval = $signed({1'b0, SIN_TAB[kk]});
    cval = (mid <= DIR_HALF) ? $signed({1'b0, COS_TAB[kk]})
                             : -$signed({1'b0, COS_TAB[kk]});
    py_nxt = y_r * cval;
    px_nxt = x_r * sval;
    diff   = py_r - px_r;
    trial  = res_r + bit_r;
    q3     = 28'(res_r[12:0]) * 28'(RECIP3);
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      BK_IDLE: begin
        if (head.valid) begin
          x_r     <= head.job.gy[GRAD_W-1] ? -head.job.gx : head.job.gx;
          y_r     <= head.job.gy[GRAD_W-1] ? -head.job.gy : head.job.gy;
          yzero_r <= (head.job.gy == '0);
          xneg_r  <= head.job.gx[GRAD_W-1];
          last_r  <= head.job.last;
        end
      end
      BK_SQR: begin
        sqa_r <= (2*GRAD_W)'(x_r * x_r);
        sqb_r <= (2*GRAD_W)'(y_r * y_r);
      end
      BK_ADD: begin
        v_r   <= SQ_W'(sqa_r) + SQ_W'(sqb_r);
        res_r <= '0;
        bit_r <= SQRT_BIT0;
        cnt_r <= '0;
        lo_r  <= '0;
        hi_r  <= DIR_TOP;
      end
      BK_RUN: begin
        cnt_r <= cnt_r + CNT_W'(1);
        // square root, one result bit a cycle
        if (int'(cnt_r) < SQRT_STEPS) begin
          if (v_r >= trial) begin
            v_r   <= v_r - trial;
            res_r <= (res_r >> 1) + bit_r;
          end else begin
            res_r <= res_r >> 1;
          end
          bit_r <= bit_r >> 2;
        end
        if (cnt_r == CNT_MAG) mag_r <= (q3[27:16] > 12'(MAG_MAX)) ? MAG_MAX : q3[23:16];
        // angle binary search: multiply, then compare
        if (!cnt_r[0]) begin
          py_r  <= py_nxt;
          px_r  <= px_nxt;
          mid_r <= mid;
        end else if (!diff[PROD_W-1]) begin
          lo_r <= mid_r;
        end else begin
          hi_r <= mid_r - 8'd1;
        end
      end
      BK_DONE: ;
      default: ;
    endcase
  end

  assign out_res.magnitude     = mag_r;
  assign out_res.direction     = yzero_r ? (xneg_r ? DIR_FLAT : '0) : lo_r;
  assign out_res.last_of_frame = last_r;

endmodule

[src/sgmd_checker.sv]
module sgmd_checker import sgmd_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_magnitude,
  input logic [7:0] out_direction,
  input logic       out_last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_magnitude) &&
    $stable(out_direction) && $stable(out_last))
    else $error("result changed while stalled");

  // reset empties the result register
  a_rst_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // folded angle stays within half a turn
  a_dir_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_direction <= DIR_FLAT)
    else $error("direction out of range");

  // back end always recomputes between two results
  a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> !out_valid)
    else $error("result valid right after handoff");

endmodule

bind sobel_gradient_magnitude_direction sgmd_checker u_sgmd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_res.valid),
  .out_ready     (out_res.ready),
  .out_magnitude (out_res.magnitude),
  .out_direction (out_res.direction),
  .out_last      (out_res.last_of_frame)
);
